[rtl/dzti_pkg.sv]
package dzti_pkg;

   localparam int BLOCK_SIZE = 8;
   localparam int NB = (BLOCK_SIZE < 2) ? 2 : ((BLOCK_SIZE > 8) ? 8 : BLOCK_SIZE);
   localparam int NN = NB * NB;
   localparam int IDX_W = (NB > 2) ? $clog2(NB) : 1;
   localparam int ADDR_W = 6;
   localparam int STORE_DEPTH = 64;
   localparam int PIX_W = 8;
   localparam int COEF_W = 16;
   localparam int PART_W = 20;
   localparam int CS_W = 16;
   localparam int PROD_W = PART_W + CS_W;
   localparam int ACC_W = PROD_W + 4;
   localparam int CYCLE = 4 * NB;

   localparam logic [15:0] COS_ROM [42] = '{
      16'd11585, 16'd16384, 16'd11585,
      16'd9459, 16'd13377, 16'd11585, 16'd6689,
      16'd8192, 16'd11585, 16'd10703, 16'd8192, 16'd4433,
      16'd7327, 16'd10362, 16'd9855, 16'd8383, 16'd6091, 16'd3202,
      16'd6689, 16'd9459, 16'd9137, 16'd8192, 16'd6689, 16'd4730, 16'd2448,
      16'd6193, 16'd8758, 16'd8538, 16'd7890, 16'd6847, 16'd5460, 16'd3800, 16'd1949,
      16'd5793, 16'd8192, 16'd8035, 16'd7568, 16'd6811, 16'd5793, 16'd4551, 16'd3135,
      16'd1598
   };
   localparam int ROM_BASE [7] = '{0, 3, 7, 12, 18, 25, 33};

   typedef enum logic [1:0] {
      PASS_FWD_COL = 2'd0,
      PASS_FWD_ROW = 2'd1,
      PASS_INV_COL = 2'd2,
      PASS_INV_ROW = 2'd3
   } pass_type;

   typedef struct packed {
      logic              issue;
      logic              first;
      logic              last;
      pass_type          pass;
      logic [IDX_W-1:0]  i;
      logic [IDX_W-1:0]  j;
      logic [IDX_W-1:0]  k;
      logic              load_we;
      logic [ADDR_W-1:0] load_addr;
      logic              emit_rd;
      logic [ADDR_W-1:0] emit_addr;
      logic              capture;
   } cmd_type;

   typedef struct packed {
      logic wr_done;
   } status_type;

   // Q2.14 basis value for frequency f at spatial index x
   function automatic logic signed [CS_W-1:0] basis(input int f, input int x);
      int b;
      int k;
      logic signed [CS_W-1:0] r;
      b = ROM_BASE[NB-2];
      k = ((2 * x + 1) * f) % CYCLE;
      if (k > 2 * NB) k = CYCLE - k;
      if (f == 0) r = COS_ROM[b];
      else if (k == NB) r = '0;
      else if (k < NB) r = COS_ROM[b + 1 + k];
      else r = -$signed(COS_ROM[b + 1 + (2 * NB - k)]);
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] zz_pos(input int r, input int c);
      int s;
      int preceding;
      int lo;
      int hi;
      int off;
      s = r + c;
      if (s < NB) preceding = s * (s + 1) / 2;
      else preceding = NN - (2 * NB - 1 - s) * (2 * NB - s) / 2;
      lo = (s + 1 > NB) ? s + 1 - NB : 0;
      hi = (s < NB - 1) ? s : NB - 1;
      off = s[0] ? (r - lo) : (hi - r);
      return ADDR_W'(preceding + off);
   endfunction

endpackage

[rtl/dzti_req_if.sv]
interface dzti_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_pixel;
   modport source (output valid, output in_pixel, input ready);
   modport sink (input valid, input in_pixel, output ready);
endinterface

[rtl/dzti_rsp_if.sv]
interface dzti_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_pixel;
   logic       block_last;
   modport source (output valid, output out_pixel, output block_last, input ready);
   modport sink (input valid, input out_pixel, input block_last, output ready);
endinterface

[rtl/dzti_csr_if.sv]
interface dzti_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/dzti_ram.sv]
module dzti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end
   assign rdata = rdata_ff;
endmodule

[rtl/dzti_ctrl.sv]
module dzti_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_last,
   output dzti_pkg::cmd_type   cmd,
   input  dzti_pkg::status_type status
);
   import dzti_pkg::*;

   typedef enum logic [2:0] {
      S_LOAD, S_ISSUE, S_WAIT, S_EMIT_RD, S_EMIT_WAIT, S_EMIT_OUT
   } state_type;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NB - 1);
   localparam logic [ADDR_W-1:0] N_LAST = ADDR_W'(NN - 1);

   state_type         state_ff;
   pass_type          pass_ff;
   logic [IDX_W-1:0]  i_ff, j_ff, k_ff;
   logic [ADDR_W-1:0] count_ff;
   logic              rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         pass_ff <= PASS_FWD_COL;
         i_ff <= '0;
         j_ff <= '0;
         k_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD: begin
               if (req_valid) begin
                  if (count_ff == N_LAST) begin
                     count_ff <= '0;
                     state_ff <= S_ISSUE;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
            end
            S_ISSUE: begin
               if (k_ff == IDX_LAST) begin
                  k_ff <= '0;
                  state_ff <= S_WAIT;
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
            end
            S_WAIT: begin
               if (status.wr_done) begin
                  state_ff <= S_ISSUE;
                  if (j_ff == IDX_LAST) begin
                     j_ff <= '0;
                     if (i_ff == IDX_LAST) begin
                        i_ff <= '0;
                        if (pass_ff == PASS_INV_ROW) begin
                           pass_ff <= PASS_FWD_COL;
                           state_ff <= S_EMIT_RD;
                        end else begin
                           pass_ff <= pass_type'(pass_ff + 2'd1);
                        end
                     end else begin
                        i_ff <= i_ff + 1'b1;
                     end
                  end else begin
                     j_ff <= j_ff + 1'b1;
                  end
               end
            end
            S_EMIT_RD: state_ff <= S_EMIT_WAIT;
            S_EMIT_WAIT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (count_ff == N_LAST) begin
                     count_ff <= '0;
                     state_ff <= S_LOAD;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                     state_ff <= S_EMIT_RD;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   always_comb begin
      cmd.issue = (state_ff == S_ISSUE);
      cmd.first = (k_ff == '0);
      cmd.last = (k_ff == IDX_LAST);
      cmd.pass = pass_ff;
      cmd.i = i_ff;
      cmd.j = j_ff;
      cmd.k = k_ff;
      cmd.load_we = (state_ff == S_LOAD) && req_valid;
      cmd.load_addr = count_ff;
      cmd.emit_rd = (state_ff == S_EMIT_RD);
      cmd.emit_addr = count_ff;
      cmd.capture = (state_ff == S_EMIT_WAIT);
   end

   assign req_ready = (state_ff == S_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_last = (count_ff == N_LAST);
endmodule

[rtl/dzti_datapath.sv]
module dzti_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  dzti_pkg::cmd_type    cmd,
   output dzti_pkg::status_type status,
   input  logic [7:0]           in_pixel,
   input  logic [5:0]           keep_limit,
   output logic [7:0]           out_pixel
);
   import dzti_pkg::*;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NB - 1);

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c);
      return ADDR_W'(int'(r) * NB + int'(c));
   endfunction

   // floor((x + 2^(s-1)) / 2^s) as an arithmetic shift of the biased sum
   function automatic logic signed [ACC_W-1:0] rnd(input logic signed [ACC_W-1:0] x,
                                                   input int s);
      logic signed [ACC_W-1:0] v;
      v = x + (ACC_W'(1) <<< (s - 1));
      return v >>> s;
   endfunction

   logic [ADDR_W-1:0]       rd_addr;
   logic signed [CS_W-1:0]  basis_in;
   logic [PIX_W-1:0]        pix_rdata;
   logic [COEF_W-1:0]       coef_rdata;
   logic [PART_W-1:0]       part_rdata;

   logic                    v1_ff, first1_ff, last1_ff;
   pass_type                pass1_ff;
   logic [IDX_W-1:0]        i1_ff, j1_ff;
   logic signed [CS_W-1:0]  basis1_ff;
   logic signed [PART_W-1:0] opnd;

   logic                    v2_ff, first2_ff, last2_ff;
   pass_type                pass2_ff;
   logic [IDX_W-1:0]        i2_ff, j2_ff;
   logic signed [PROD_W-1:0] prod2_ff;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    v3_ff;
   pass_type                pass3_ff;
   logic [IDX_W-1:0]        i3_ff, j3_ff;
   logic signed [ACC_W-1:0] sum3_ff;

   logic signed [ACC_W-1:0] r10, r18, pix_val;
   logic                    pix_we, part_we, coef_we;
   logic [ADDR_W-1:0]       wr_addr, pix_waddr;
   logic [PIX_W-1:0]        pix_wdata, pix_res;
   logic [PART_W-1:0]       part_wdata;
   logic [COEF_W-1:0]       coef_wdata;
   logic [7:0]              out_pixel_ff;

   always_comb begin
      case (cmd.pass)
         PASS_FWD_COL: begin
            rd_addr = addr_of(cmd.k, cmd.j);
            basis_in = basis(int'(cmd.i), int'(cmd.k));
         end
         PASS_FWD_ROW: begin
            rd_addr = addr_of(cmd.i, cmd.k);
            basis_in = basis(int'(cmd.j), int'(cmd.k));
         end
         PASS_INV_COL: begin
            rd_addr = addr_of(cmd.k, cmd.j);
            basis_in = basis(int'(cmd.k), int'(cmd.i));
         end
         default: begin
            rd_addr = addr_of(cmd.i, cmd.k);
            basis_in = basis(int'(cmd.k), int'(cmd.j));
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff && last2_ff;
      end
      first1_ff <= cmd.first;
      last1_ff <= cmd.last;
      pass1_ff <= cmd.pass;
      i1_ff <= cmd.i;
      j1_ff <= cmd.j;
      basis1_ff <= basis_in;
      first2_ff <= first1_ff;
      last2_ff <= last1_ff;
      pass2_ff <= pass1_ff;
      i2_ff <= i1_ff;
      j2_ff <= j1_ff;
      prod2_ff <= opnd * basis1_ff;
      if (v2_ff) acc_ff <= acc_in;
      sum3_ff <= acc_in;
      pass3_ff <= pass2_ff;
      i3_ff <= i2_ff;
      j3_ff <= j2_ff;
      if (cmd.capture) out_pixel_ff <= pix_rdata;
   end

   always_comb begin
      case (pass1_ff)
         PASS_FWD_COL: opnd = PART_W'($signed({1'b0, pix_rdata}) - 10'sd128);
         PASS_INV_COL: opnd = PART_W'($signed(coef_rdata));
         default:      opnd = $signed(part_rdata);
      endcase
   end

   assign acc_in = (first2_ff ? '0 : acc_ff) + ACC_W'(prod2_ff);

   always_comb begin
      r10 = rnd(sum3_ff, 10);
      r18 = rnd(sum3_ff, 18);
      wr_addr = addr_of(i3_ff, j3_ff);
      if (r10 > ACC_W'(524287)) part_wdata = 20'h7ffff;
      else if (r10 < -ACC_W'(524288)) part_wdata = 20'h80000;
      else part_wdata = r10[PART_W-1:0];
      if (zz_pos(int'(i3_ff), int'(j3_ff)) > keep_limit) coef_wdata = '0;
      else if (r18 > ACC_W'(32767)) coef_wdata = 16'h7fff;
      else if (r18 < -ACC_W'(32768)) coef_wdata = 16'h8000;
      else coef_wdata = r18[COEF_W-1:0];
      pix_val = r18 + ACC_W'(128);
      if (pix_val < 0) pix_res = 8'd0;
      else if (pix_val > ACC_W'(255)) pix_res = 8'd255;
      else pix_res = pix_val[PIX_W-1:0];
      part_we = v3_ff && (pass3_ff == PASS_FWD_COL || pass3_ff == PASS_INV_COL);
      coef_we = v3_ff && (pass3_ff == PASS_FWD_ROW);
      pix_we = cmd.load_we || (v3_ff && pass3_ff == PASS_INV_ROW);
      pix_waddr = cmd.load_we ? cmd.load_addr : wr_addr;
      pix_wdata = cmd.load_we ? in_pixel : pix_res;
   end

   dzti_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_pixel_store (
      .clock(clock), .we(pix_we), .waddr(pix_waddr), .wdata(pix_wdata),
      .raddr(cmd.emit_rd ? cmd.emit_addr : rd_addr), .rdata(pix_rdata)
   );
   dzti_ram #(.WIDTH(COEF_W), .DEPTH(STORE_DEPTH)) u_coefficient_store (
      .clock(clock), .we(coef_we), .waddr(wr_addr), .wdata(coef_wdata),
      .raddr(rd_addr), .rdata(coef_rdata)
   );
   dzti_ram #(.WIDTH(PART_W), .DEPTH(STORE_DEPTH)) u_partial_store (
      .clock(clock), .we(part_we), .waddr(wr_addr), .wdata(part_wdata),
      .raddr(rd_addr), .rdata(part_rdata)
   );

   assign status.wr_done = v3_ff;
   assign out_pixel = out_pixel_ff;
   // every write-back carries the last tap tag of its element, checked here
   a_last_tag: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> $past(v2_ff) && $past(last2_ff)) else $error("write without last tag");
   a_idx: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> cmd.k <= IDX_LAST) else $error("tap index out of range");
   a_no_clash: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_we && v3_ff)) else $error("pixel store write clash");
endmodule

[rtl/dct_zigzag_truncate_idct.sv]
// dct_zigzag_truncate_idct: 2-D DCT, zigzag truncation and inverse DCT of
// one N-by-N block of 8-bit pixels (N = 8 by default).
//
// Channels: req_ch takes one pixel item per handshake in raster order;
// rsp_ch returns the N*N reconstructed pixels in raster order, block_last
// set on the final one; csr_ch writes keep_limit (highest zigzag position
// kept). Write csr only while the block is idle.
//
// Timing: loading takes one pixel per cycle while valid is high. After
// the last pixel four matrix passes run on a single multiply-accumulate
// unit: for each of the 4*N*N results the N taps are issued, then the
// controller waits for the pipeline to write that result back.
// Each output pixel then goes through store read, capture and handshake.
// The single shared MAC and the one read port of each store set this order.
//
// Reset: keep_limit returns to 63, the load count to zero; stores hold
// whatever they held. When the receiver stalls, the current output item
// holds and the block waits; no new pixel is taken until the block is out.
module dct_zigzag_truncate_idct (
   input logic  clock,
   input logic  reset,
   dzti_req_if.sink   req_ch,
   dzti_rsp_if.source rsp_ch,
   dzti_csr_if.sink   csr_ch
);
   import dzti_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [5:0] keep_limit_ff;

   // keep_limit: always ready, write on handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_limit_ff <= 6'd63;
      end else if (csr_ch.valid) begin
         keep_limit_ff <= csr_ch.data;
      end
   end
   assign csr_ch.ready = 1'b1;

   dzti_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_last(rsp_ch.block_last),
      .cmd(cmd), .status(status)
   );

   dzti_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .in_pixel(req_ch.in_pixel), .keep_limit(keep_limit_ff),
      .out_pixel(rsp_ch.out_pixel)
   );

   // loading and emitting never overlap
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid)) else $error("load during emit");
   // the final item of a block hands back to loading
   a_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && rsp_ch.block_last |=> req_ch.ready)
      else $error("no return to load");
   // a register write lands in keep_limit
   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_ch.valid && csr_ch.ready |=> keep_limit_ff == $past(csr_ch.data))
      else $error("keep_limit not written");
endmodule

[verif/dct_zigzag_truncate_idct_test.sv]
`timescale 1ns / 100ps

module dct_zigzag_truncate_idct_test;
   import dzti_pkg::*;

   typedef struct {
      logic [7:0] pixel;
      logic       last;
   } recon_type;

   logic clock;
   logic reset;

   dzti_req_if req_ch ();
   dzti_rsp_if rsp_ch ();
   dzti_csr_if csr_ch ();

   dct_zigzag_truncate_idct uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // Predictor state: our own copy of the block being loaded and the limit
   logic [7:0] block_pixels [64];
   int         fill_count;
   logic [5:0] keep_limit_model;
   recon_type  recon_queue [$];
   int         error_count;
   bit         rsp_gaps_on;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cosine value for frequency f at spatial index x, Q2.14
   function automatic longint cosine_at(int f, int x);
      int b;
      int k;
      b = ROM_BASE[NB-2];
      if (f == 0) return longint'(COS_ROM[b]);
      k = ((2 * x + 1) * f) % (4 * NB);
      if (k > 2 * NB) k = 4 * NB - k;
      if (k == NB) return 0;
      if (k < NB) return longint'(COS_ROM[b + 1 + k]);
      return -longint'(COS_ROM[b + 1 + (2 * NB - k)]);
   endfunction

   // Round half up: floor((v + 2^(s-1)) / 2^s); >>> on longint floors
   function automatic longint round_half_up(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int zigzag_index(int r, int c);
      int s;
      int preceding;
      int lo;
      int hi;
      s = r + c;
      if (s < NB) preceding = s * (s + 1) / 2;
      else preceding = NN - (2 * NB - 1 - s) * (2 * NB - s) / 2;
      lo = (s + 1 > NB) ? s + 1 - NB : 0;
      hi = (s < NB - 1) ? s : NB - 1;
      return preceding + ((s % 2 == 1) ? (r - lo) : (hi - r));
   endfunction

   // Transform, truncate and reconstruct the stored block; queue its pixels
   task automatic reconstruct_block();
      longint partial [64];
      longint coef [64];
      longint acc;
      for (int i = 0; i < NB; i++)
         for (int j = 0; j < NB; j++) begin
            acc = 0;
            for (int k = 0; k < NB; k++)
               acc += cosine_at(i, k) * (longint'(block_pixels[k*NB+j]) - 128);
            partial[i*NB+j] = clip(round_half_up(acc, 10), -524288, 524287);
         end
      for (int i = 0; i < NB; i++)
         for (int j = 0; j < NB; j++) begin
            acc = 0;
            for (int k = 0; k < NB; k++)
               acc += partial[i*NB+k] * cosine_at(j, k);
            acc = clip(round_half_up(acc, 18), -32768, 32767);
            // drop every coefficient past the zigzag limit
            if (zigzag_index(i, j) > keep_limit_model) acc = 0;
            coef[i*NB+j] = acc;
         end
      for (int i = 0; i < NB; i++)
         for (int j = 0; j < NB; j++) begin
            acc = 0;
            for (int k = 0; k < NB; k++)
               acc += cosine_at(k, i) * coef[k*NB+j];
            partial[i*NB+j] = clip(round_half_up(acc, 10), -524288, 524287);
         end
      for (int i = 0; i < NB; i++)
         for (int j = 0; j < NB; j++) begin
            recon_type r;
            acc = 0;
            for (int k = 0; k < NB; k++)
               acc += partial[i*NB+k] * cosine_at(k, j);
            r.pixel = 8'(clip(round_half_up(acc, 18) + 128, 0, 255));
            r.last = (i * NB + j == NN - 1);
            recon_queue.push_back(r);
         end
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Random gap length: mostly short, now and then long
   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   // Send one pixel item; predict on acceptance. Valid stays high after
   // acceptance so that a following item can go back to back.
   task automatic send_pixel(logic [7:0] pixel, bit gaps);
      int gap;
      gap = gaps ? gap_length() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.in_pixel <= pixel;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      block_pixels[fill_count] = pixel;
      if (fill_count == NN - 1) begin
         fill_count = 0;
         reconstruct_block();
      end else begin
         fill_count++;
      end
   endtask

   // Drop valid, hold until every expected pixel is back, then settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (recon_queue.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_keep_limit(logic [5:0] value);
      wait_idle();
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      keep_limit_model = value;
   endtask

   // Extremes: checkerboard of 0 and 255, all coefficients kept, back to back
   task automatic test_directed_extremes();
      write_keep_limit(6'd63);
      for (int n = 0; n < NN; n++)
         send_pixel((((n / NB) + (n % NB)) % 2 == 1) ? 8'd255 : 8'd0, 1'b0);
   endtask

   // Random blocks at the lowest limit and at limit 20
   task automatic test_random_blocks();
      logic [5:0] limits [2];
      limits = '{6'd0, 6'd20};
      foreach (limits[s]) begin
         write_keep_limit(limits[s]);
         for (int n = 0; n < NN; n++) send_pixel(8'($urandom), 1'b1);
      end
   endtask

   // Receiver: random stall, compare against the oldest expected pixel
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (recon_queue.size() == 0) begin
               report_mismatch("unexpected item", rsp_ch.out_pixel, -1);
            end else begin
               recon_type want;
               want = recon_queue.pop_front();
               if (rsp_ch.out_pixel !== want.pixel)
                  report_mismatch("out_pixel", rsp_ch.out_pixel, want.pixel);
               if (rsp_ch.block_last !== want.last)
                  report_mismatch("block_last", rsp_ch.block_last, want.last);
            end
         end
         // hold ready low for a random stretch, keep it high otherwise
         if (rsp_gaps_on && $urandom_range(0, 3) == 0)
            rsp_ch.ready <= 1'b0;
         else
            rsp_ch.ready <= 1'b1;
      end
   end

   initial begin
      #20ms;
      $display("dct_zigzag_truncate_idct_test: done, errors");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.in_pixel = '0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      fill_count = 0;
      keep_limit_model = 6'd63;
      error_count = 0;
      rsp_gaps_on = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      rsp_gaps_on = 1'b1;
      test_random_blocks();
      wait_idle();
      if (error_count == 0)
         $display("dct_zigzag_truncate_idct_test: done, clean");
      else
         $display("dct_zigzag_truncate_idct_test: done, errors");
      $finish;
   end

endmodule

[dct_zigzag_truncate_idct.f]
rtl/dzti_pkg.sv
rtl/dzti_req_if.sv
rtl/dzti_rsp_if.sv
rtl/dzti_csr_if.sv
rtl/dzti_ram.sv
rtl/dzti_ctrl.sv
rtl/dzti_datapath.sv
rtl/dct_zigzag_truncate_idct.sv
verif/dct_zigzag_truncate_idct_test.sv
